/* sv/pot_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the piezo onset trigger.
// Used by every module of the block; depends on nothing.
package pot_pkg;

  localparam int SAMPLE_W = 16;
  localparam int Y_W      = 20;
  localparam int MAG_W    = 19;
  localparam int COEFF_W  = 16;
  localparam int DECAY_W  = 16;
  // The playback address port is 24 bits wide, and so is the length register.
  localparam int IDX_W    = 24;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_POLE_COEFF  = 3'd0;
  localparam cfg_idx_t CFG_THRESHOLD   = 3'd1;
  localparam cfg_idx_t CFG_DROP        = 3'd2;
  localparam cfg_idx_t CFG_DECAY       = 3'd3;
  localparam cfg_idx_t CFG_SAMPLE_LEN  = 3'd4;

  localparam logic [COEFF_W-1:0] POLE_RST      = 16'd64881;
  localparam logic [MAG_W-1:0]   THRESHOLD_RST = 19'd66;
  localparam logic [MAG_W-1:0]   DROP_RST      = 19'd66;
  localparam logic [DECAY_W-1:0] DECAY_RST     = 16'd3;
  localparam logic [IDX_W-1:0]   LENGTH_RST    = 24'd0;

  typedef struct packed {
    logic             onset;
    logic [MAG_W-1:0] peak;
  } det_res_t;

  typedef struct packed {
    logic             active;
    logic [IDX_W-1:0] index;
  } play_res_t;

endpackage

/* sv/pot_dcblock.sv */
`timescale 1ns / 1ps
// One-pole DC-blocking filter with saturation and full-wave rectifier.
// Depends on pot_pkg.
module pot_dcblock
  import pot_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [COEFF_W-1:0]  pole_coeff,
  output logic [MAG_W-1:0]    magnitude
);

  logic [SAMPLE_W-1:0]          prev_in_r;
  logic signed [Y_W-1:0]        prev_y_r;
  logic signed [Y_W+COEFF_W:0]  prod;
  logic signed [Y_W+COEFF_W:0]  prod_rnd;
  logic signed [Y_W:0]          fb;
  logic signed [Y_W+2:0]        y_sum;
  logic signed [Y_W-1:0]        y_sat;
  logic [Y_W-1:0]               y_neg;

  assign prod     = $signed({1'b0, pole_coeff}) * prev_y_r;
  assign prod_rnd = prod + (Y_W+COEFF_W+1)'(32768);
  // Arithmetic shift by 16 floors the rounded product.
  assign fb       = prod_rnd[Y_W+COEFF_W:COEFF_W];
  assign y_sum    = $signed({7'b0, sample}) - $signed({7'b0, prev_in_r})
                    + $signed({{2{fb[Y_W]}}, fb});

  always_comb begin
    if (y_sum > $signed(23'sd524287)) begin
      y_sat = 20'sh7FFFF;
    end else if (y_sum < -$signed(23'sd524288)) begin
      y_sat = 20'sh80000;
    end else begin
      y_sat = y_sum[Y_W-1:0];
    end
  end

  assign y_neg = ~y_sat + 20'd1;

  always_comb begin
    if (!y_sat[Y_W-1]) begin
      magnitude = y_sat[MAG_W-1:0];
    end else if (y_sat == 20'sh80000) begin
      magnitude = {MAG_W{1'b1}};
    end else begin
      magnitude = y_neg[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_in_r <= '0;
      prev_y_r  <= '0;
    end else if (fire) begin
      prev_in_r <= sample;
      prev_y_r  <= y_sat;
    end
  end

endmodule

/* sv/pot_detect.sv */
`timescale 1ns / 1ps
// Decaying peak tracker and once-per-peak onset detector.
// Depends on pot_pkg.
module pot_detect
  import pot_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [MAG_W-1:0]   magnitude,
  input  logic [MAG_W-1:0]   threshold,
  input  logic [MAG_W-1:0]   drop,
  input  logic [DECAY_W-1:0] decay,
  output det_res_t           res
);

  logic [MAG_W-1:0] peak_r, peak_nxt;
  logic             armed_r, armed_nxt;
  logic             armed_mid;
  logic             trig;

  always_comb begin
    armed_mid = armed_r;
    if (magnitude >= peak_r) begin
      peak_nxt  = magnitude;
      armed_mid = 1'b0;
    end else if (peak_r >= {3'b0, decay}) begin
      peak_nxt = peak_r - {3'b0, decay};
    end else begin
      peak_nxt = peak_r;
    end
  end

  // Magnitude below (peak - drop) without going negative: mag + drop < peak.
  assign trig = (({1'b0, magnitude} + {1'b0, drop}) < {1'b0, peak_nxt})
                && (peak_nxt >= threshold) && !armed_mid;
  assign armed_nxt = armed_mid | trig;

  assign res.onset = trig;
  assign res.peak  = peak_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r  <= '0;
      armed_r <= 1'b0;
    end else if (fire) begin
      peak_r  <= peak_nxt;
      armed_r <= armed_nxt;
    end
  end

endmodule

/* sv/pot_play.sv */
`timescale 1ns / 1ps
// Playback address counter restarted by an onset, stopping at the buffer length.
// Depends on pot_pkg.
module pot_play
  import pot_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic             onset,
  input  logic [IDX_W-1:0] length,
  output play_res_t        res
);

  logic [IDX_W-1:0] pos_r, pos_nxt, pos_a, pos_inc;
  logic             playing_r, playing_nxt, playing_a;

  assign playing_a = onset | playing_r;
  assign pos_a     = onset ? '0 : pos_r;
  assign pos_inc   = pos_a + IDX_W'(1);

  always_comb begin
    res.active  = 1'b0;
    res.index   = '0;
    pos_nxt     = pos_a;
    playing_nxt = playing_a;
    if (playing_a) begin
      if (pos_a < length) begin
        res.active  = 1'b1;
        res.index   = pos_a;
        pos_nxt     = pos_inc;
        playing_nxt = pos_inc < length;
      end else begin
        playing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      playing_r <= 1'b0;
    end else if (fire) begin
      pos_r     <= pos_nxt;
      playing_r <= playing_nxt;
    end
  end

endmodule

/* sv/piezo_onset_trigger_unit.sv */
`timescale 1ns / 1ps
// Piezo onset trigger: DC blocker, rectifier, peak tracker, onset and playback index.
// A beat held in the input register is written to the result register when it fires.
// Throughput: one beat per cycle while out_stall does not hold the result; the filter
// feedback multiply and peak update are combinational between the two registers.
// Reset (synchronous, active low) restores defaults, clears all but the data registers.
// Depends on pot_pkg, pot_dcblock, pot_detect and pot_play.
module piezo_onset_trigger_unit
  import pot_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SAMPLE_W-1:0]  in_piezo_sample,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [MAG_W-1:0]     out_magnitude,
  output logic [MAG_W-1:0]     out_peak_level,
  output logic                 out_onset,
  output logic                 out_play_active,
  output logic [IDX_W-1:0]     out_play_index,
  input  logic                 cfg_we,
  input  cfg_idx_t             cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [COEFF_W-1:0]  pole_r;
  logic [MAG_W-1:0]    thr_r;
  logic [MAG_W-1:0]    drop_r;
  logic [DECAY_W-1:0]  decay_r;
  logic [IDX_W-1:0]    len_r;

  logic                in_valid_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic                out_valid_r;
  logic [MAG_W-1:0]    mag_r;
  logic [MAG_W-1:0]    peak_r;
  logic                onset_r;
  logic                active_r;
  logic [IDX_W-1:0]    index_r;

  logic                proc_ready;
  logic                fire;
  logic                accept;
  logic [MAG_W-1:0]    magnitude;
  det_res_t            det;
  play_res_t           play;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_r  <= POLE_RST;
      thr_r   <= THRESHOLD_RST;
      drop_r  <= DROP_RST;
      decay_r <= DECAY_RST;
      len_r   <= LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLE_COEFF: pole_r  <= cfg_wdata[COEFF_W-1:0];
        CFG_THRESHOLD:  thr_r   <= cfg_wdata[MAG_W-1:0];
        CFG_DROP:       drop_r  <= cfg_wdata[MAG_W-1:0];
        CFG_DECAY:      decay_r <= cfg_wdata[DECAY_W-1:0];
        CFG_SAMPLE_LEN: len_r   <= cfg_wdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // The held input beat is processed when the result register is free or draining.
  assign proc_ready = !out_valid_r || !out_stall;
  assign fire       = in_valid_r && proc_ready;
  assign in_stall   = in_valid_r && !proc_ready;
  assign accept     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_piezo_sample;
    end
    if (fire) begin
      mag_r    <= magnitude;
      peak_r   <= det.peak;
      onset_r  <= det.onset;
      active_r <= play.active;
      index_r  <= play.index;
    end
  end

  pot_dcblock u_dcblock (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .sample     (sample_r),
    .pole_coeff (pole_r),
    .magnitude  (magnitude)
  );

  pot_detect u_detect (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .magnitude (magnitude),
    .threshold (thr_r),
    .drop      (drop_r),
    .decay     (decay_r),
    .res       (det)
  );

  pot_play u_play (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .onset  (det.onset),
    .length (len_r),
    .res    (play)
  );

  assign out_valid       = out_valid_r;
  assign out_magnitude   = mag_r;
  assign out_peak_level  = peak_r;
  assign out_onset       = onset_r;
  assign out_play_active = active_r;
  assign out_play_index  = index_r;

endmodule
